FILE: src/lac_pkg.sv
`timescale 1ns / 1ps

package lac_pkg;

    localparam int SHIFT_W = 12;
    localparam int LEVEL_W = 8;
    localparam int VALUE_W = 8;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Item kinds carried on s_tuser
    localparam logic [MODE_W-1:0] MODE_CLOCK      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_LOW   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_HIGH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOAD_LEVEL = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRATE = 2'd2;

    // Previous feedback bit: 0, 1, or not yet seen since reset
    localparam logic [1:0] LAST_UNKNOWN = 2'd3;

    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 8'sd127;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -8'sd128;

    typedef struct packed {
        logic [SHIFT_W-1:0]        tap_mask;
        logic signed [LEVEL_W-1:0] volume;
        logic                      integrate;
    } lac_cfg_t;

    typedef struct packed {
        logic [SHIFT_W-1:0]        shift;
        logic signed [LEVEL_W-1:0] level;
        logic [1:0]                last_bit;
    } lac_state_t;

endpackage

FILE: src/lac_cfg.sv
`timescale 1ns / 1ps

module lac_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lac_pkg::CFG_DATA_W-1:0] cfg_data,
    output lac_pkg::lac_cfg_t             cfg
);
    import lac_pkg::*;

    lac_cfg_t cfg_reg;

    // Register writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAP_MASK:  cfg_reg.tap_mask  <= cfg_data[SHIFT_W-1:0];
                REG_VOLUME:    cfg_reg.volume    <= cfg_data[LEVEL_W-1:0];
                REG_INTEGRATE: cfg_reg.integrate <= cfg_data[0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/lac_step.sv
`timescale 1ns / 1ps

module lac_step (
    input  lac_pkg::lac_cfg_t             cfg,
    input  lac_pkg::lac_state_t           cur,
    input  logic [lac_pkg::MODE_W-1:0]    mode,
    input  logic [lac_pkg::VALUE_W-1:0]   value,
    output lac_pkg::lac_state_t           nxt,
    output logic                          new_bit
);
    import lac_pkg::*;

    logic                        fb_bit;
    logic signed [LEVEL_W-1:0]   lvl;
    logic signed [LEVEL_W:0]     sum;
    logic signed [LEVEL_W-1:0]   sat;
    logic                        changed;

    // Feedback: XNOR of tapped bits, level is volume or its inverse
    assign fb_bit  = ~(^(cfg.tap_mask & cur.shift));
    assign lvl     = fb_bit ? ~cfg.volume : cfg.volume;
    assign sum     = {cur.level[LEVEL_W-1], cur.level} + {lvl[LEVEL_W-1], lvl};
    assign changed = ({1'b0, fb_bit} != cur.last_bit);

    // Saturate the 9-bit sum to the signed byte range
    always_comb
    begin
        if (sum > $signed({LEVEL_MAX[LEVEL_W-1], LEVEL_MAX}))
            sat = LEVEL_MAX;
        else if (sum < $signed({LEVEL_MIN[LEVEL_W-1], LEVEL_MIN}))
            sat = LEVEL_MIN;
        else
            sat = sum[LEVEL_W-1:0];
    end

    // Next state per item kind
    always_comb
    begin
        nxt     = cur;
        new_bit = 1'b0;
        case (mode)
            MODE_CLOCK:
            begin
                new_bit   = fb_bit;
                nxt.shift = {cur.shift[SHIFT_W-2:0], fb_bit};
                if (cfg.integrate)
                    nxt.level = sat;
                else if (changed)
                    nxt.level = lvl;
                if (changed)
                    nxt.last_bit = {1'b0, fb_bit};
            end
            MODE_LOAD_LOW:
                nxt.shift = {cur.shift[SHIFT_W-1:VALUE_W], value};
            MODE_LOAD_HIGH:
                nxt.shift = {value[VALUE_W-1:4], cur.shift[VALUE_W-1:0]};
            MODE_LOAD_LEVEL:
                nxt.level = value;
            default:
                nxt = cur;
        endcase
    end

endmodule

FILE: src/lfsr_audio_channel.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields (low bit up)
// s_*       in   tuser: mode[1:0]; tdata: value[7:0]
// m_*       out  tdata: sample[7:0], shift_state[19:8], new_bit[20]
// cfg_*     in   index 0 tap_mask, 1 volume, 2 integrate_enable
//
// One beat per cycle sustained while m_tready stays high; an accepted beat passes the input
// register, then the LFSR step and saturating add into the output register.
// Reset clears shift register, output level and configuration; the previous
// bit reads as unknown. An output stall holds one beat in each register, then
// s_tready drops.

module lfsr_audio_channel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // value[7:0]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample[7:0], shift_state[19:8], new_bit[20], zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import lac_pkg::*;

    lac_cfg_t              cfg;
    lac_state_t            state_reg;
    lac_state_t            state_next;
    logic                  step_bit;

    logic                  in_valid_reg;
    logic [MODE_W-1:0]     in_mode_reg;
    logic [VALUE_W-1:0]    in_value_reg;

    logic                  out_valid_reg;
    logic [LEVEL_W-1:0]    out_sample_reg;
    logic [SHIFT_W-1:0]    out_shift_reg;
    logic                  out_bit_reg;

    logic                  advance;

    lac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lac_step u_step (
        .cfg     (cfg),
        .cur     (state_reg),
        .mode    (in_mode_reg),
        .value   (in_value_reg),
        .nxt     (state_next),
        .new_bit (step_bit)
    );

    // Item moves to the output register when that register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg  <= s_tuser;
            in_value_reg <= s_tdata;
        end
    end

    // Channel state, updated as each item is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.shift    <= '0;
            state_reg.level    <= '0;
            state_reg.last_bit <= LAST_UNKNOWN;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= state_next.level;
            out_shift_reg  <= state_next.shift;
            out_bit_reg    <= step_bit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_bit_reg, out_shift_reg, out_sample_reg};

endmodule

FILE: src/lfsr_audio_channel_chk.sv
`timescale 1ns / 1ps

module lfsr_audio_channel_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // A fed-back one lands in shift bit 0
    a_bit_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |-> m_tdata[8])
        else $error("new_bit not reflected in shift_state");

    // Input only blocks when both stages are full and output stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // A rising output valid follows an accepted input beat through the input and output registers
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output beat without input beat");

endmodule

bind lfsr_audio_channel lfsr_audio_channel_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
